// ===== rtl/spq_pkg.sv =====
// Package for the stable priority queue: sizes, command and status codes,
// and the request, result and stored entry types.
// No dependencies.
package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = IDX_W + 1;

  localparam int CMD_W       = 2;
  localparam int URG_W       = 3;
  localparam int KEY_W       = 32;
  localparam int CONTACT_W   = 48;
  localparam int STATUS_W    = 3;
  localparam int POS_W       = 9;

  localparam logic [URG_W-1:0] URG_MIN = URG_W'(1);
  localparam logic [URG_W-1:0] URG_MAX = URG_W'(5);

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_BADURG   = 3'd4
  } status_t;

  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [URG_W-1:0]     urgency;
    logic [KEY_W-1:0]     patient_key;
    logic [CONTACT_W-1:0] contact_value;
  } in_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [URG_W-1:0]     out_urgency;
    logic [KEY_W-1:0]     out_key;
    logic [CONTACT_W-1:0] out_contact;
    logic [POS_W-1:0]     position;
    logic [POS_W-1:0]     entry_count;
    logic                 is_empty;
  } out_res_t;

  typedef struct packed {
    logic [URG_W-1:0]     urg;
    logic [KEY_W-1:0]     key;
    logic [CONTACT_W-1:0] contact;
  } entry_t;

endpackage

// ===== rtl/stable_priority_queue.sv =====
// Top level of the stable priority queue: entry memory held as a ring,
// command sequencer and registered result.
// Depends on spq_pkg.
//
// Usage: present a request on in_req and raise start while busy is low; the
// request is taken at that clock edge. Commands are insert, pop head and
// lookup by key. Exactly one result follows per request: out_res is valid
// for the single cycle in which out_strobe is high, and the receiver cannot
// hold it off. busy is low again in that same cycle, so the next request
// may be taken while the result is shown.
// With N entries held: refusals, the unused command, an insert into an
// empty queue and a lookup on an empty queue are answered at once from idle;
// pop passes through S_POP; lookup reads up to N entries in S_LOOK; insert
// shifts entries in S_INS and may end in S_PUT. The single read port of the
// entry memory sets this walk: the insert goes from the tail towards the head,
// reading and writing one entry per cycle; the lookup reads one per cycle.
// Reset clears the count, the head pointer and the sequencer; the entry
// memory is not cleared, and no entry is read before it has been written.
module stable_priority_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  spq_pkg::in_req_t  in_req,
  output logic              out_strobe,
  output spq_pkg::out_res_t out_res
);
  import spq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_INS  = 5'b00010,
    S_PUT  = 5'b00100,
    S_POP  = 5'b01000,
    S_LOOK = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   occ_r, occ_nxt;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  entry_t             new_r, new_nxt;
  logic               out_strobe_r, out_strobe_nxt;
  out_res_t           out_res_r, out_res_nxt;

  entry_t             mem [QUEUE_DEPTH];
  entry_t             rd_data_r;
  logic [CNT_W-1:0]   rd_log;
  logic [CNT_W-1:0]   wr_log;
  logic               wr_en;
  entry_t             wr_data;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;

  logic               accept;
  logic               full;
  logic               urg_ok;
  logic               finish;
  status_t            fin_status;
  entry_t             fin_entry;
  logic [CNT_W-1:0]   fin_pos;

  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                            input logic [CNT_W-1:0] l);
    logic [SUM_W-1:0] s;
    s = SUM_W'(head) + SUM_W'(l);
    if (s >= SUM_W'(QUEUE_DEPTH)) begin
      s = s - SUM_W'(QUEUE_DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  assign accept  = start && (state_r == S_IDLE);
  assign full    = (occ_r == CNT_W'(QUEUE_DEPTH));
  assign urg_ok  = (in_req.urgency >= URG_MIN) && (in_req.urgency <= URG_MAX);
  assign rd_addr = phys(head_r, rd_log);
  assign wr_addr = phys(head_r, wr_log);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt  = state_r;
    occ_nxt    = occ_r;
    head_nxt   = head_r;
    idx_nxt    = idx_r;
    new_nxt    = new_r;
    rd_log     = '0;
    wr_log     = '0;
    wr_en      = 1'b0;
    wr_data    = new_r;
    finish     = 1'b0;
    fin_status = ST_DONE;
    fin_entry  = '0;
    fin_pos    = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          new_nxt.urg     = in_req.urgency;
          new_nxt.key     = in_req.patient_key;
          new_nxt.contact = in_req.contact_value;
          case (cmd_t'(in_req.command))
            CMD_INSERT: begin
              if (full) begin
                finish     = 1'b1;
                fin_status = ST_FULL;
              end else if (!urg_ok) begin
                finish     = 1'b1;
                fin_status = ST_BADURG;
              end else if (occ_r == '0) begin
                wr_en           = 1'b1;
                wr_data.urg     = in_req.urgency;
                wr_data.key     = in_req.patient_key;
                wr_data.contact = in_req.contact_value;
                occ_nxt         = occ_r + CNT_W'(1);
                finish          = 1'b1;
              end else begin
                rd_log    = occ_r - CNT_W'(1);
                idx_nxt   = occ_r;
                state_nxt = S_INS;
              end
            end
            CMD_POP: begin
              if (occ_r == '0) begin
                finish     = 1'b1;
                fin_status = ST_EMPTY;
              end else begin
                state_nxt = S_POP;
              end
            end
            CMD_LOOKUP: begin
              if (occ_r == '0) begin
                finish     = 1'b1;
                fin_status = ST_NOTFOUND;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_LOOK;
              end
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      S_INS: begin
        wr_en  = 1'b1;
        wr_log = idx_r;
        if (rd_data_r.urg >= new_r.urg) begin
          occ_nxt   = occ_r + CNT_W'(1);
          finish    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          wr_data = rd_data_r;
          idx_nxt = idx_r - CNT_W'(1);
          if (idx_r == CNT_W'(1)) begin
            state_nxt = S_PUT;
          end else begin
            rd_log = idx_r - CNT_W'(2);
          end
        end
      end
      S_PUT: begin
        wr_en     = 1'b1;
        wr_log    = idx_r;
        occ_nxt   = occ_r + CNT_W'(1);
        finish    = 1'b1;
        state_nxt = S_IDLE;
      end
      S_POP: begin
        fin_entry = rd_data_r;
        occ_nxt   = occ_r - CNT_W'(1);
        head_nxt  = phys(head_r, CNT_W'(1));
        finish    = 1'b1;
        state_nxt = S_IDLE;
      end
      S_LOOK: begin
        if (rd_data_r.key == new_r.key) begin
          fin_entry = rd_data_r;
          fin_pos   = idx_r + CNT_W'(1);
          finish    = 1'b1;
          state_nxt = S_IDLE;
        end else if (idx_r + CNT_W'(1) == occ_r) begin
          fin_status = ST_NOTFOUND;
          finish     = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          rd_log  = idx_r + CNT_W'(1);
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_strobe_nxt          = finish;
    out_res_nxt             = out_res_r;
    if (finish) begin
      out_res_nxt.status      = fin_status;
      out_res_nxt.out_urgency = fin_entry.urg;
      out_res_nxt.out_key     = fin_entry.key;
      out_res_nxt.out_contact = fin_entry.contact;
      out_res_nxt.position    = POS_W'(fin_pos);
      out_res_nxt.entry_count = POS_W'(occ_nxt);
      out_res_nxt.is_empty    = (occ_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      occ_r        <= '0;
      head_r       <= '0;
      idx_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      occ_r        <= occ_nxt;
      head_r       <= head_nxt;
      idx_r        <= idx_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    new_r     <= new_nxt;
    out_res_r <= out_res_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

`ifndef SYNTHESIS
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> (state_r == S_IDLE))
    else $error("result shown while a request is still in work");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(QUEUE_DEPTH))
    else $error("occupancy beyond queue depth");

  a_occ_moves_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(occ_r) |-> out_strobe_r)
    else $error("occupancy changed without a result");

  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_req.command == CMD_POP) && (occ_r == '0)) |=>
      (out_strobe_r && (out_res_r.status == ST_EMPTY)))
    else $error("pop on empty queue not refused at once");

  a_count_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> ((out_res_r.entry_count == POS_W'(occ_r)) &&
                      (out_res_r.is_empty == (occ_r == '0))))
    else $error("reported count differs from occupancy");
`endif

endmodule
